### design/trrc_pkg.sv
`timescale 1ns / 1ps

package trrc_pkg;

   localparam int LetterCount = 26;
   localparam int AsciiUpperA = 65;
   localparam int AsciiUpperZ = 90;
   localparam int AsciiLowerA = 97;
   localparam int AsciiLowerZ = 122;
   localparam int CaseGap     = 32;
   localparam int LetterWidth = 5;

   typedef logic [LetterWidth-1:0] letter_type;
   typedef letter_type table_type [LetterCount];

   typedef struct packed {
      letter_type fast;
      letter_type middle;
      letter_type slow;
   } offsets_type;

   // Base wirings, zero-based: entry j is the output letter for input letter j.
   localparam table_type Rotor0 = '{
      5'd9,  5'd6,  5'd3,  5'd16, 5'd14, 5'd23, 5'd20, 5'd18, 5'd2,  5'd0,
      5'd12, 5'd8,  5'd5,  5'd17, 5'd21, 5'd19, 5'd15, 5'd13, 5'd4,  5'd22,
      5'd10, 5'd1,  5'd11, 5'd25, 5'd24, 5'd7
   };
   localparam table_type Rotor1 = '{
      5'd13, 5'd19, 5'd25, 5'd15, 5'd18, 5'd5,  5'd1,  5'd14, 5'd10, 5'd12,
      5'd22, 5'd17, 5'd2,  5'd9,  5'd3,  5'd8,  5'd21, 5'd11, 5'd0,  5'd4,
      5'd24, 5'd20, 5'd23, 5'd7,  5'd6,  5'd16
   };
   localparam table_type Rotor2 = '{
      5'd9,  5'd21, 5'd8,  5'd20, 5'd1,  5'd7,  5'd19, 5'd2,  5'd3,  5'd24,
      5'd0,  5'd10, 5'd4,  5'd16, 5'd25, 5'd15, 5'd14, 5'd18, 5'd6,  5'd23,
      5'd13, 5'd17, 5'd12, 5'd22, 5'd5,  5'd11
   };
   localparam table_type Reflector = '{
      5'd16, 5'd24, 5'd7,  5'd14, 5'd6,  5'd13, 5'd4,  5'd2,  5'd21, 5'd15,
      5'd20, 5'd25, 5'd19, 5'd5,  5'd3,  5'd9,  5'd0,  5'd23, 5'd22, 5'd12,
      5'd10, 5'd8,  5'd18, 5'd17, 5'd1,  5'd11
   };

   function automatic table_type invert_table(table_type wiring);
      table_type inverse;
      for (int j = 0; j < LetterCount; j++) begin
         inverse[j] = '0;
      end
      for (int j = 0; j < LetterCount; j++) begin
         inverse[wiring[j]] = letter_type'(j);
      end
      return inverse;
   endfunction

   localparam table_type Inverse0 = invert_table(Rotor0);
   localparam table_type Inverse1 = invert_table(Rotor1);
   localparam table_type Inverse2 = invert_table(Rotor2);

endpackage

### design/trrc_if.sv
`timescale 1ns / 1ps

interface trrc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;

   modport source (output valid, output char_in, input ready);
   modport sink (input valid, input char_in, output ready);
endinterface

interface trrc_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] char_out;
   logic       rejected;

   modport source (output valid, output char_out, output rejected, input ready);
   modport sink (input valid, input char_out, input rejected, output ready);
endinterface

### design/trrc_datapath.sv
`timescale 1ns / 1ps

module trrc_datapath (
   input  logic [7:0]             char_in,
   input  trrc_pkg::offsets_type  offsets,
   output logic [6:0]             char_out,
   output logic                   rejected
);

   function automatic trrc_pkg::letter_type sub_mod(trrc_pkg::letter_type a,
                                                    trrc_pkg::letter_type b);
      logic [5:0] s;
      s = {1'b0, a} + 6'(trrc_pkg::LetterCount) - {1'b0, b};
      if (s >= 6'(trrc_pkg::LetterCount)) begin
         s = s - 6'(trrc_pkg::LetterCount);
      end
      return s[4:0];
   endfunction

   function automatic trrc_pkg::letter_type add_mod(trrc_pkg::letter_type a,
                                                    trrc_pkg::letter_type b);
      logic [5:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= 6'(trrc_pkg::LetterCount)) begin
         s = s - 6'(trrc_pkg::LetterCount);
      end
      return s[4:0];
   endfunction

   logic                 is_lower;
   logic                 is_upper;
   logic [7:0]           folded;
   logic [7:0]           letter_offset;
   trrc_pkg::letter_type k0;
   trrc_pkg::letter_type fwd1;
   trrc_pkg::letter_type fwd2;
   trrc_pkg::letter_type fwd3;
   trrc_pkg::letter_type refl;
   trrc_pkg::letter_type back3;
   trrc_pkg::letter_type back2;
   trrc_pkg::letter_type back1;

   always_comb begin
      is_lower = (char_in >= 8'(trrc_pkg::AsciiLowerA)) &&
                 (char_in <= 8'(trrc_pkg::AsciiLowerZ));
      folded   = is_lower ? char_in - 8'(trrc_pkg::CaseGap) : char_in;
      is_upper = (folded >= 8'(trrc_pkg::AsciiUpperA)) &&
                 (folded <= 8'(trrc_pkg::AsciiUpperZ));
      letter_offset = folded - 8'(trrc_pkg::AsciiUpperA);
      k0 = letter_offset[4:0];

      fwd1  = trrc_pkg::Rotor0[sub_mod(k0, offsets.fast)];
      fwd2  = trrc_pkg::Rotor1[sub_mod(fwd1, offsets.middle)];
      fwd3  = trrc_pkg::Rotor2[sub_mod(fwd2, offsets.slow)];
      refl  = trrc_pkg::Reflector[fwd3];
      back3 = add_mod(trrc_pkg::Inverse2[refl], offsets.slow);
      back2 = add_mod(trrc_pkg::Inverse1[back3], offsets.middle);
      back1 = add_mod(trrc_pkg::Inverse0[back2], offsets.fast);

      rejected = !is_upper;
      char_out = is_upper ? {2'b00, back1} + 7'(trrc_pkg::AsciiUpperA) : 7'd0;
   end

endmodule

### design/three_rotor_reflector_cipher.sv
`timescale 1ns / 1ps
// Three-rotor reflector cipher. Each word on the req channel carries one ASCII
// byte in char_in. Letters of either case are enciphered through three
// rotors, a fixed reflector and the rotors again, and leave on the rsp channel
// as an uppercase letter in char_out with rejected low. Any other byte leaves
// as char_out zero with rejected high and does not step the rotors.
// Every accepted word yields exactly one rsp word, in order.
// The block has two register stages: an input register and a result
// register, with the whole cipher path between them. An accepted word moves
// from the input register into the result register, which presents it on rsp.
// Throughput is one word per cycle while rsp does not stall; the rotor offsets
// update in the same cycle that a letter moves into the result register, so
// consecutive letters see the stepped offsets without a gap.
// Synchronous reset empties both stages and sets all rotor offsets to zero.
// When the receiver holds rsp.ready low, the result register holds its word,
// the input register fills, and req.ready then drops until rsp drains.
module three_rotor_reflector_cipher (
   input  logic          clock,
   input  logic          reset,
   trrc_req_if.sink      req,
   trrc_rsp_if.source    rsp
);

   logic                  s1_valid_ff;
   logic                  s1_valid_in;
   logic [7:0]            s1_char_ff;
   logic [7:0]            s1_char_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [6:0]            rsp_char_ff;
   logic [6:0]            rsp_char_in;
   logic                  rsp_rejected_ff;
   logic                  rsp_rejected_in;
   trrc_pkg::offsets_type offsets_ff;
   trrc_pkg::offsets_type offsets_in;

   logic                  rsp_advance;
   logic                  s1_advance;
   logic [6:0]            cipher_char;
   logic                  cipher_rejected;

   localparam trrc_pkg::letter_type LastOffset = 5'(trrc_pkg::LetterCount - 1);

   trrc_datapath u_datapath (
      .char_in  (s1_char_ff),
      .offsets  (offsets_ff),
      .char_out (cipher_char),
      .rejected (cipher_rejected)
   );

   always_comb begin
      rsp_advance = !rsp_valid_ff || rsp.ready;
      s1_advance  = !s1_valid_ff || rsp_advance;

      s1_valid_in = s1_valid_ff;
      s1_char_in  = s1_char_ff;
      if (s1_advance) begin
         s1_valid_in = req.valid;
         s1_char_in  = req.char_in;
      end

      rsp_valid_in    = rsp_valid_ff;
      rsp_char_in     = rsp_char_ff;
      rsp_rejected_in = rsp_rejected_ff;
      offsets_in      = offsets_ff;
      if (rsp_advance) begin
         rsp_valid_in = s1_valid_ff;
         if (s1_valid_ff) begin
            rsp_char_in     = cipher_char;
            rsp_rejected_in = cipher_rejected;
            if (!cipher_rejected) begin
               if (offsets_ff.fast == LastOffset) begin
                  offsets_in.fast = '0;
                  if (offsets_ff.middle == LastOffset) begin
                     offsets_in.middle = '0;
                     if (offsets_ff.slow == LastOffset) begin
                        offsets_in.slow = '0;
                     end else begin
                        offsets_in.slow = offsets_ff.slow + 5'd1;
                     end
                  end else begin
                     offsets_in.middle = offsets_ff.middle + 5'd1;
                  end
               end else begin
                  offsets_in.fast = offsets_ff.fast + 5'd1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         offsets_ff   <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         offsets_ff   <= offsets_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_char_ff      <= s1_char_in;
      rsp_char_ff     <= rsp_char_in;
      rsp_rejected_ff <= rsp_rejected_in;
   end

   assign req.ready    = s1_advance;
   assign rsp.valid    = rsp_valid_ff;
   assign rsp.char_out = rsp_char_ff;
   assign rsp.rejected = rsp_rejected_ff;

endmodule

### design/trrc_checker.sv
`timescale 1ns / 1ps

module trrc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [6:0] rsp_char_out,
   input logic       rsp_rejected
);

   // A stalled result word must not change.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_char_out) &&
                                  $stable(rsp_rejected))
      else $error("rsp word changed while stalled");

   // Reset leaves both stages empty, so the block is ready with nothing to show.
   assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("pipeline not empty after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rejected |-> rsp_char_out == 7'd0)
      else $error("rejected word carries a character");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_rejected |->
         rsp_char_out >= 7'(trrc_pkg::AsciiUpperA) &&
         rsp_char_out <= 7'(trrc_pkg::AsciiUpperZ))
      else $error("enciphered character is not an uppercase letter");

endmodule

bind three_rotor_reflector_cipher trrc_checker u_trrc_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req.ready),
   .rsp_valid    (rsp.valid),
   .rsp_ready    (rsp.ready),
   .rsp_char_out (rsp.char_out),
   .rsp_rejected (rsp.rejected)
);

### bench/three_rotor_reflector_cipher_tb.sv
`timescale 1ns / 1ps

typedef struct packed {
   logic [6:0] char_out;
   logic       rejected;
} cipher_word_type;

class cipher_scoreboard;
   localparam int RingSize  = 26;
   localparam int AsciiBias = 64;
   localparam int CaseShift = 32;

   // Base wirings of the three rotors and the reflector, as letters.
   string       wiring[4] = '{
      "JGDQOXUSCAMIFRVTPNEWKBLZYH",
      "NTZPSFBOKMWRCJDIVLAEYUXHGQ",
      "JVIUBHTCDYAKEQZPOSGXNRMWFL",
      "QYHOGNECVPUZTFDJAXWMKISRBL"
   };
   int          fast_pos;
   int          middle_pos;
   int          slow_pos;
   int          error_count;
   cipher_word_type pending[$];

   function new();
      fast_pos    = 0;
      middle_pos  = 0;
      slow_pos    = 0;
      error_count = 0;
   endfunction

   function int wire_of(int rotor, int pos);
      return int'(wiring[rotor][pos]) - AsciiBias;
   endfunction

   function int pass_forward(int rotor, int k, int offset);
      return wire_of(rotor, (k - 1 - offset + RingSize) % RingSize);
   endfunction

   function int pass_backward(int rotor, int v, int offset);
      int hit;
      hit = 0;
      for (int j = 0; j < RingSize; j++) begin
         if (wire_of(rotor, j) == v) begin
            hit = j;
         end
      end
      return ((hit + offset) % RingSize) + 1;
   endfunction

   function void note_input(logic [7:0] char_in);
      int              c;
      int              k;
      cipher_word_type word;
      c = int'(char_in);
      if (c >= 97 && c <= 122) begin
         c = c - CaseShift;
      end
      if (c < 65 || c > 90) begin
         word.char_out = '0;
         word.rejected = 1'b1;
      end else begin
         k = c - AsciiBias;
         k = pass_forward(0, k, fast_pos);
         k = pass_forward(1, k, middle_pos);
         k = pass_forward(2, k, slow_pos);
         k = pass_forward(3, k, 0);
         k = pass_backward(2, k, slow_pos);
         k = pass_backward(1, k, middle_pos);
         k = pass_backward(0, k, fast_pos);
         fast_pos = (fast_pos + 1) % RingSize;
         if (fast_pos == 0) begin
            middle_pos = (middle_pos + 1) % RingSize;
            if (middle_pos == 0) begin
               slow_pos = (slow_pos + 1) % RingSize;
            end
         end
         word.char_out = 7'(k + AsciiBias);
         word.rejected = 1'b0;
      end
      pending.push_back(word);
   endfunction

   task report_mismatch(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      error_count++;
   endtask

   task check_result(logic [6:0] char_out, logic rejected);
      cipher_word_type want;
      if (pending.size() == 0) begin
         report_mismatch($sformatf("unexpected word char_out=%0d rejected=%0b",
                                   char_out, rejected));
      end else begin
         want = pending.pop_front();
         if (char_out !== want.char_out) begin
            report_mismatch($sformatf("char_out %0d, expected %0d",
                                      char_out, want.char_out));
         end
         if (rejected !== want.rejected) begin
            report_mismatch($sformatf("rejected %0b, expected %0b",
                                      rejected, want.rejected));
         end
      end
   endtask
endclass

module three_rotor_reflector_cipher_tb;
   localparam int RandomWords = 1950;
   localparam int IdleLimit   = 2000;
   localparam int HoldCycles  = 300;
   localparam int HoldAfter   = 400;

   logic clock;
   logic reset;
   int   idle_cycles;
   int   send_gap_max;
   int   take_gap_max;

   cipher_scoreboard sb;

   trrc_req_if req_ch ();
   trrc_rsp_if rsp_ch ();

   three_rotor_reflector_cipher dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int pick_gap_max();
      case ($urandom_range(0, 3))
         0, 1:    return 0;
         2:       return 3;
         default: return 15;
      endcase
   endfunction

   function automatic logic [7:0] random_char();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 12) begin
         return 8'($urandom_range(65, 90));
      end else if (pick < 17) begin
         return 8'($urandom_range(97, 122));
      end
      return 8'($urandom_range(0, 255));
   endfunction

   task send_word(input logic [7:0] char_in);
      int gap;
      gap = $urandom_range(0, send_gap_max);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.char_in <= char_in;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Every accepted word is noted here; the scoreboard predicts the result.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            sb.note_input(req_ch.char_in);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            sb.check_result(rsp_ch.char_out, rsp_ch.rejected);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == IdleLimit) begin
            $display("three_rotor_reflector_cipher test failed");
            $finish;
         end
      end
   end

   // The receiver stalls at random, and once holds off long enough to back up
   // the block and stall its input.
   initial begin
      int taken;
      int gap;
      taken = 0;
      take_gap_max = 0;
      rsp_ch.ready <= 1'b0;
      @(negedge reset);
      forever begin
         if (taken % 80 == 0) begin
            take_gap_max = pick_gap_max();
         end
         if (taken == HoldAfter) begin
            rsp_ch.ready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
         end else begin
            gap = $urandom_range(0, take_gap_max);
            if (gap > 0) begin
               rsp_ch.ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         taken++;
      end
   end

   initial begin
      logic [7:0] directed[$];
      sb = new();
      send_gap_max = 0;
      reset = 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.char_in <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Letter edges of both cases, bytes just outside each letter range,
      // and letter patterns with the top bit set.
      directed = '{8'h41, 8'h5A, 8'h61, 8'h7A, 8'h40, 8'h5B, 8'h60, 8'h7B,
                   8'h00, 8'hFF, 8'h7F, 8'h80, 8'hC1, 8'hDA, 8'hE1, 8'hFA,
                   8'h30, 8'h20, 8'h4D, 8'h6D, 8'h41, 8'h41, 8'h41};
      foreach (directed[i]) begin
         send_word(directed[i]);
      end

      for (int n = 0; n < RandomWords; n++) begin
         if (n % 150 == 0) begin
            send_gap_max = pick_gap_max();
         end
         send_word(random_char());
      end
      req_ch.valid <= 1'b0;
      @(posedge clock);

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (sb.error_count == 0) begin
         $display("three_rotor_reflector_cipher test passed");
      end else begin
         $display("three_rotor_reflector_cipher test failed");
      end
      $finish;
   end
endmodule
